// ===== hdl/rmmst_pkg.sv =====
// Shared types and constants for the range min/max sparse table unit.
// Payload structs for both channels, command and status codes, default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmmst_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_LEVELS       = 11;
  localparam int DEF_VALUE_WIDTH  = 32;

  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
    logic [INDEX_W-1:0]       left_index;
    logic [INDEX_W-1:0]       right_index;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_min;
    logic signed [DATA_W-1:0] range_max;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       element_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/rmmst_stream_if.sv =====
// Valid/ready stream interface carrying one payload struct per beat.
// Payload type is a parameter; used with rmmst_pkg::req_t and rmmst_pkg::rsp_t.
`timescale 1ns / 1ps
`default_nettype none

interface rmmst_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== hdl/rmmst_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/rmmst_minmax.sv =====
// Shared compare unit: merges two (min, max) key pairs into one.
// Keys are sign-flipped values, so plain unsigned order is signed order.
`timescale 1ns / 1ps
`default_nettype none

module rmmst_minmax #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a_min,
  input  logic [WIDTH-1:0] a_max,
  input  logic [WIDTH-1:0] b_min,
  input  logic [WIDTH-1:0] b_max,
  output logic [WIDTH-1:0] lo,
  output logic [WIDTH-1:0] hi
);

  assign lo = (a_min < b_min) ? a_min : b_min;
  assign hi = (a_max > b_max) ? a_max : b_max;

endmodule

`default_nettype wire

// ===== hdl/range_min_max_sparse_table_unit.sv =====
// Range min/max sparse table unit: top level with sequencer and window stores.
// Depends on rmmst_pkg, rmmst_stream_if, rmmst_ram and rmmst_minmax.
//
// Usage: commands arrive on the request stream (clear, append, query) and each
// gives exactly one beat on the response stream, in order.
// An append writes level 0 of the new position, then fills one window level per
// cycle through the shared min/max unit, reading the level below at the window
// start and reusing the window just built for its upper half.
// From accept to response: clear, bad query, full append and the unused code
// go straight to the done state; a query passes a two-port registered store
// read, then one compare; an append into a non-empty table fills its window
// levels in the fill state, up to level LEVELS - 1 (10 with the default sizes).
// One item is in work at a time; request ready is low while it runs.
// A finished response sits in an output register; the next item is accepted
// while it waits, and a later result holds in the sequencer until the
// receiver takes the earlier one.
// Reset empties the table (count zero) and drops any pending response; the
// window stores are not cleared, as only entries of held elements are read.
`timescale 1ns / 1ps
`default_nettype none

module range_min_max_sparse_table_unit #(
  parameter int MAX_ELEMENTS = rmmst_pkg::DEF_MAX_ELEMENTS,
  parameter int LEVELS       = rmmst_pkg::DEF_LEVELS,
  parameter int VALUE_WIDTH  = rmmst_pkg::DEF_VALUE_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  rmmst_stream_if.sink   request,
  rmmst_stream_if.source response
);

  import rmmst_pkg::*;

  localparam int PW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int LW = $clog2(LEVELS);
  localparam int AW = $clog2(LEVELS * (2 ** PW));
  localparam int QW = ((INDEX_W > CW) ? INDEX_W : CW) + 1;
  localparam int XW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_QRY  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state;
  logic [CW-1:0]          held_count;
  logic [LW-1:0]          level;
  logic [VALUE_WIDTH-1:0] run_min;
  logic [VALUE_WIDTH-1:0] run_max;
  rsp_t                   res;
  rsp_t                   out_pl;
  logic                   out_valid;

  logic                   accept;
  logic [CW-1:0]          held_next;
  logic                   full;
  logic [XW-1:0]          value_ext;
  logic [VALUE_WIDTH-1:0] in_key;

  logic [QW-1:0]          q_left;
  logic [QW-1:0]          q_right;
  logic [QW-1:0]          q_len;
  logic [QW-1:0]          q_start_b;
  logic                   q_bad;
  logic [LW-1:0]          q_level;

  logic [LW:0]            level_inc;
  logic [CW-1:0]          fill_start;
  logic [CW-1:0]          next_start;
  logic                   next_ok;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_min;
  logic [VALUE_WIDTH-1:0] wr_max;
  logic [AW-1:0]          rd_addr_a;
  logic [AW-1:0]          rd_addr_b;
  logic [VALUE_WIDTH-1:0] rd_min_a;
  logic [VALUE_WIDTH-1:0] rd_min_b;
  logic [VALUE_WIDTH-1:0] rd_max_a;
  logic [VALUE_WIDTH-1:0] rd_max_b;

  logic [VALUE_WIDTH-1:0] mm_b_min;
  logic [VALUE_WIDTH-1:0] mm_b_max;
  logic [VALUE_WIDTH-1:0] mm_lo;
  logic [VALUE_WIDTH-1:0] mm_hi;
  logic [XW-1:0]          lo_ext;
  logic [XW-1:0]          hi_ext;

  assign request.ready    = (state == S_IDLE);
  assign accept           = request.valid && request.ready;
  assign response.valid   = out_valid;
  assign response.payload = out_pl;

  assign held_next = held_count + CW'(1);
  assign full      = (held_count >= CW'(MAX_ELEMENTS));

  // Keys carry the sign bit flipped
  assign value_ext = XW'($unsigned(request.payload.value));
  assign in_key    = value_ext[VALUE_WIDTH-1:0] ^ SIGN_BIT;
  assign lo_ext    = XW'(mm_lo ^ SIGN_BIT);
  assign hi_ext    = XW'(mm_hi ^ SIGN_BIT);

  // Query decode
  assign q_left    = QW'(request.payload.left_index);
  assign q_right   = QW'(request.payload.right_index);
  assign q_bad     = (q_left > q_right) || (q_right >= QW'(held_count));
  assign q_len     = q_right - q_left + QW'(1);
  assign q_start_b = q_right + QW'(1) - (QW'(1) << q_level);

  always_comb begin
    q_level = '0;
    for (int i = 1; i < LEVELS; i++) begin
      if ((q_len >> i) != '0) begin
        q_level = LW'(i);
      end
    end
  end

  // Fill walk: level is the level written this cycle
  assign level_inc  = {1'b0, level} + (LW + 1)'(1);
  assign fill_start = held_count - (CW'(1) << level);
  assign next_start = held_count - (CW'(1) << level_inc);
  assign next_ok    = (level_inc < (LW + 1)'(LEVELS)) && ((held_count >> level_inc) != '0);

  always_comb begin
    if (state == S_FILL) begin
      wr_en     = 1'b1;
      wr_addr   = AW'({level, fill_start[PW-1:0]});
      wr_min    = mm_lo;
      wr_max    = mm_hi;
      rd_addr_a = AW'({level, next_start[PW-1:0]});
      rd_addr_b = AW'({level, next_start[PW-1:0]});
    end else begin
      wr_en     = accept && (request.payload.command == CMD_APPEND) && !full;
      wr_addr   = AW'({{LW{1'b0}}, held_count[PW-1:0]});
      wr_min    = in_key;
      wr_max    = in_key;
      if (request.payload.command == CMD_QUERY) begin
        rd_addr_a = AW'({q_level, q_left[PW-1:0]});
        rd_addr_b = AW'({q_level, q_start_b[PW-1:0]});
      end else begin
        // first fill read: level 0 at the position before the new one
        rd_addr_a = AW'({{LW{1'b0}}, held_count[PW-1:0] - PW'(1)});
        rd_addr_b = AW'({{LW{1'b0}}, held_count[PW-1:0] - PW'(1)});
      end
    end
  end

  rmmst_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LEVELS * (2 ** PW))
  ) u_min_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_min),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_min_a),
    .rd_data_b (rd_min_b)
  );

  rmmst_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LEVELS * (2 ** PW))
  ) u_max_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_max),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_max_a),
    .rd_data_b (rd_max_b)
  );

  assign mm_b_min = (state == S_QRY) ? rd_min_b : run_min;
  assign mm_b_max = (state == S_QRY) ? rd_max_b : run_max;

  rmmst_minmax #(
    .WIDTH (VALUE_WIDTH)
  ) u_minmax (
    .a_min (rd_min_a),
    .a_max (rd_max_a),
    .b_min (mm_b_min),
    .b_max (mm_b_max),
    .lo    (mm_lo),
    .hi    (mm_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && response.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.range_min <= '0;
            res.range_max <= '0;
            unique case (request.payload.command)
              CMD_CLEAR: begin
                held_count        <= '0;
                res.status        <= STATUS_OK;
                res.element_count <= '0;
                state             <= S_DONE;
              end
              CMD_APPEND: begin
                if (full) begin
                  res.status        <= STATUS_FULL;
                  res.element_count <= COUNT_W'(held_count);
                  state             <= S_DONE;
                end else begin
                  held_count        <= held_next;
                  res.status        <= STATUS_OK;
                  res.element_count <= COUNT_W'(held_next);
                  run_min           <= in_key;
                  run_max           <= in_key;
                  level             <= LW'(1);
                  state             <= (held_count != '0) ? S_FILL : S_DONE;
                end
              end
              CMD_QUERY: begin
                res.status        <= q_bad ? STATUS_RANGE : STATUS_OK;
                res.element_count <= COUNT_W'(held_count);
                state             <= q_bad ? S_DONE : S_QRY;
              end
              default: begin
                res.status        <= STATUS_OK;
                res.element_count <= COUNT_W'(held_count);
                state             <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          run_min <= mm_lo;
          run_max <= mm_hi;
          if (next_ok) begin
            level <= level_inc[LW-1:0];
          end else begin
            state <= S_DONE;
          end
        end
        S_QRY: begin
          res.range_min <= $signed(lo_ext[DATA_W-1:0]);
          res.range_max <= $signed(hi_ext[DATA_W-1:0]);
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || response.ready) begin
            out_pl    <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
